// File: src/assert_macros.svh
// assertion macros used by the checker file etrb_checker.sv
// each macro expects clk and arst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/etrb_pkg.sv
// shared types and codes for the event trace ring buffer
// no dependencies
`timescale 1ns / 1ps

package etrb_pkg;

	localparam int RING_DEPTH_DEF = 32;

	localparam logic OP_EMIT     = 1'b0;
	localparam logic OP_SNAPSHOT = 1'b1;

	localparam logic [1:0] KIND_EMIT_OK  = 2'd0;
	localparam logic [1:0] KIND_EMIT_REJ = 2'd1;
	localparam logic [1:0] KIND_RECORD   = 2'd2;
	localparam logic [1:0] KIND_END      = 2'd3;

	typedef struct packed {
		logic               opcode;
		logic [31:0]        event_kind;
		logic [63:0]        object_ident;
		logic [31:0]        user_ident;
		logic [31:0]        group_ident;
		logic [31:0]        requested_bits;
		logic signed [31:0] outcome_code;
		logic [63:0]        stamp_in;
		logic [7:0]         cpu_in;
		logic [63:0]        after_seq;
		logic [7:0]         max_records;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [63:0]        seq_out;
		logic [63:0]        stamp_out;
		logic [63:0]        object_out;
		logic [31:0]        event_out;
		logic [7:0]         cpu_out;
		logic [31:0]        user_out;
		logic [31:0]        group_out;
		logic [31:0]        requested_out;
		logic signed [31:0] outcome_out;
		logic [7:0]         record_count;
		logic               last;
	} rsp_item_t;

	// one ring slot as held in the record memory
	typedef struct packed {
		logic [63:0]        seq;
		logic [63:0]        stamp;
		logic [63:0]        object;
		logic [31:0]        event_kind;
		logic [7:0]         cpu;
		logic [31:0]        user;
		logic [31:0]        group;
		logic [31:0]        requested;
		logic signed [31:0] outcome;
	} record_t;

endpackage

// File: src/etrb_stream_if.sv
// valid/ready stream channel carrying one payload struct per transfer
// payload type is set per instance, typically from etrb_pkg
`timescale 1ns / 1ps

interface etrb_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/event_trace_ring_buffer_unit.sv
// event trace ring buffer: record memory, sequence counter and snapshot walker
// depends on etrb_pkg and etrb_stream_if
`timescale 1ns / 1ps

// Emits (opcode 0) may follow one another in every cycle while the response side
// keeps up; each returns one accepted or rejected item, and each accepted one
// writes one record into the ring memory. A snapshot (opcode 1) blocks the command
// side while it walks N slots, N = min(newest - after_seq, newest, RING_DEPTH)
// or less when max_records cuts it short: three setup states work out the window,
// every slot in it passes a read state and a check state on the record memory, one
// more read state sees that the walk is over, then the finish state loads the end
// item; a check state that finds a record and the finish state wait out response
// stalls. A snapshot that walks nothing (max_records 0, or after_seq at or past
// newest) passes two setup states and the finish state. Valid bits are cleared by
// reset, so there is no clearing pass after reset.
module event_trace_ring_buffer_unit #(
	parameter int RING_DEPTH = etrb_pkg::RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	etrb_stream_if.sink           cmd,
	etrb_stream_if.source         rsp
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam logic [63:0]       DEPTH_SEQ = 64'(RING_DEPTH);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W:0]    DEPTH_WRAP = (CNT_W + 1)'(RING_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP1 = 3'd1;
	localparam logic [2:0] ST_SETUP2 = 3'd2;
	localparam logic [2:0] ST_SETUP3 = 3'd3;
	localparam logic [2:0] ST_RD     = 3'd4;
	localparam logic [2:0] ST_CHK    = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	etrb_pkg::cmd_item_t cmd_item;
	etrb_pkg::rsp_item_t out_q;
	etrb_pkg::rsp_item_t out_d;
	etrb_pkg::record_t   mem [RING_DEPTH];
	etrb_pkg::record_t   rd_q;
	etrb_pkg::record_t   wr_rec;

	logic [2:0]        state_q;
	logic [63:0]       newest_q;
	logic [SLOT_W-1:0] newest_slot_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic              rd_valid_q;
	logic              out_valid_q;

	logic [63:0]       after_q;
	logic [7:0]        limit_q;
	logic [63:0]       diff_q;
	logic [CNT_W-1:0]  avail_q;
	logic              skip_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       probe_q;

	logic              out_free;
	logic              out_load;
	logic              cmd_fire;
	logic              emit_ok;
	logic              walk_done;
	logic              rd_en;
	logic              hit;
	logic [63:0]       newest_inc;
	logic [SLOT_W-1:0] newest_slot_inc;
	logic [SLOT_W-1:0] slot_inc;
	logic [CNT_W-1:0]  off;
	logic [CNT_W-1:0]  ns_ext;
	logic [CNT_W:0]    wrap_sum;
	logic [SLOT_W-1:0] start_slot;

	assign cmd_item  = cmd.data;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign emit_ok   = cmd_fire && (cmd_item.opcode == etrb_pkg::OP_EMIT) &&
		(cmd_item.event_kind != 32'd0);

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign newest_inc      = newest_q + 64'd1;
	assign newest_slot_inc = (newest_slot_q == LAST_SLOT) ? '0 : newest_slot_q + SLOT_W'(1);
	assign slot_inc        = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);

	// the walk stops when the window is used up or the limit is reached
	assign walk_done = (rem_q == '0) || (8'(count_q) == limit_q);
	assign rd_en     = (state_q == ST_RD) && !walk_done;
	assign hit       = rd_valid_q && (rd_q.seq == probe_q);

	// first slot of the window, counted back from the newest slot
	assign off        = rem_q - CNT_W'(1);
	assign ns_ext     = CNT_W'(newest_slot_q);
	assign wrap_sum   = (CNT_W + 1)'(ns_ext) + DEPTH_WRAP - (CNT_W + 1)'(off);
	assign start_slot = (ns_ext >= off) ? SLOT_W'(ns_ext - off) : SLOT_W'(wrap_sum);

	// a new result item is loaded into the output register
	assign out_load = (cmd_fire && (cmd_item.opcode == etrb_pkg::OP_EMIT)) ||
		((state_q == ST_CHK) && hit && out_free) ||
		((state_q == ST_FINISH) && out_free);

	always_comb begin
		wr_rec            = '0;
		wr_rec.seq        = newest_inc;
		wr_rec.stamp      = cmd_item.stamp_in;
		wr_rec.object     = cmd_item.object_ident;
		wr_rec.event_kind = cmd_item.event_kind;
		wr_rec.cpu        = cmd_item.cpu_in;
		wr_rec.user       = cmd_item.user_ident;
		wr_rec.group      = cmd_item.group_ident;
		wr_rec.requested  = cmd_item.requested_bits;
		wr_rec.outcome    = cmd_item.outcome_code;
	end

	always_comb begin
		out_d = '0;
		case (state_q)
			ST_CHK: begin
				out_d.kind          = etrb_pkg::KIND_RECORD;
				out_d.seq_out       = rd_q.seq;
				out_d.stamp_out     = rd_q.stamp;
				out_d.object_out    = rd_q.object;
				out_d.event_out     = rd_q.event_kind;
				out_d.cpu_out       = rd_q.cpu;
				out_d.user_out      = rd_q.user;
				out_d.group_out     = rd_q.group;
				out_d.requested_out = rd_q.requested;
				out_d.outcome_out   = rd_q.outcome;
			end
			ST_FINISH: begin
				out_d.kind         = etrb_pkg::KIND_END;
				out_d.seq_out      = newest_q;
				out_d.record_count = 8'(count_q);
				out_d.last         = 1'b1;
			end
			default: begin
				out_d.last = 1'b1;
				if (emit_ok) begin
					out_d.kind    = etrb_pkg::KIND_EMIT_OK;
					out_d.seq_out = newest_inc;
				end else begin
					out_d.kind = etrb_pkg::KIND_EMIT_REJ;
				end
			end
		endcase
	end

	// record memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (emit_ok) begin
			mem[newest_slot_inc] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			newest_q      <= '0;
			newest_slot_q <= '0;
			valid_q       <= '0;
			rd_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			skip_q        <= 1'b0;
			rem_q         <= '0;
			count_q       <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			if (rd_en) begin
				rd_valid_q <= valid_q[slot_q];
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd_item.opcode == etrb_pkg::OP_SNAPSHOT) begin
							state_q <= ST_SETUP1;
						end else if (emit_ok) begin
							newest_q                 <= newest_inc;
							newest_slot_q            <= newest_slot_inc;
							valid_q[newest_slot_inc] <= 1'b1;
						end
					end
				end
				ST_SETUP1: begin
					skip_q  <= (limit_q == 8'd0) || (after_q >= newest_q);
					count_q <= '0;
					state_q <= ST_SETUP2;
				end
				ST_SETUP2: begin
					rem_q   <= (diff_q < 64'(avail_q)) ? diff_q[CNT_W-1:0] : avail_q;
					state_q <= skip_q ? ST_FINISH : ST_SETUP3;
				end
				ST_SETUP3: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= walk_done ? ST_FINISH : ST_CHK;
				end
				ST_CHK: begin
					if (!hit) begin
						rem_q   <= rem_q - CNT_W'(1);
						state_q <= ST_RD;
					end else if (out_free) begin
						rem_q   <= rem_q - CNT_W'(1);
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			after_q <= cmd_item.after_seq;
			limit_q <= cmd_item.max_records;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if (state_q == ST_SETUP1) begin
			diff_q  <= newest_q - after_q;
			avail_q <= (newest_q >= DEPTH_SEQ) ? DEPTH_CNT : newest_q[CNT_W-1:0];
		end
		if (state_q == ST_SETUP3) begin
			probe_q <= newest_q - 64'(off);
			slot_q  <= start_slot;
		end
		if (state_q == ST_CHK && (!hit || out_free)) begin
			probe_q <= probe_q + 64'd1;
			slot_q  <= slot_inc;
		end
	end

endmodule

// File: src/etrb_checker.sv
// port-level checks for the event trace ring buffer, bound to the top level
// depends on etrb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module etrb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       cmd_opcode,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_kind,
	input logic       rsp_last,
	input logic [7:0] rsp_count
);

	// a pending response transfer is not withdrawn
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	// emit results are always the only result of their command
	`ASSERT_IMPLY(a_emit_last, rsp_valid && (rsp_kind == etrb_pkg::KIND_EMIT_OK || rsp_kind == etrb_pkg::KIND_EMIT_REJ), rsp_last && rsp_count == 8'd0, "emit result malformed")

	// record items never close a snapshot
	`ASSERT_IMPLY(a_rec_not_last, rsp_valid && rsp_kind == etrb_pkg::KIND_RECORD, !rsp_last && rsp_count == 8'd0, "record item malformed")

	// a snapshot holds off the command side as its setup begins
	`ASSERT_NEXT(a_snap_busy, cmd_valid && cmd_ready && cmd_opcode == etrb_pkg::OP_SNAPSHOT, !cmd_ready, "command taken during snapshot setup")

endmodule

bind event_trace_ring_buffer_unit etrb_checker u_etrb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_opcode (cmd.data.opcode),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_kind   (rsp.data.kind),
	.rsp_last   (rsp.data.last),
	.rsp_count  (rsp.data.record_count)
);

// File: test/trace_ring_checker.sv
`timescale 1ns / 1ps
// watches both channels of the event trace ring, keeps its own ring and sequence
// counter, predicts every result and compares it field by field; depends on etrb_pkg

module trace_ring_checker
	import etrb_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_item_t cmd_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp_data,
	output int        mismatches,
	output int        waiting
);

	localparam logic [63:0] DEPTH64 = 64'(RING_DEPTH);

	logic [63:0] seq_now;
	record_t     ring [RING_DEPTH];
	rsp_item_t   due_results [$];

	// applies one accepted command to the model ring and queues what it must produce
	task automatic predict_trace_results(input cmd_item_t c);
		rsp_item_t   r;
		logic [63:0] s;
		logic [63:0] lo;
		logic [7:0]  taken;
		int          slot;
		r = '0;
		taken = '0;
		if (c.opcode == OP_EMIT) begin
			r.last = 1'b1;
			if (c.event_kind == '0) begin
				r.kind = KIND_EMIT_REJ;
			end else begin
				seq_now = seq_now + 64'd1;
				slot = int'(seq_now % DEPTH64);
				ring[slot] = '{seq: seq_now, stamp: c.stamp_in, object: c.object_ident,
					event_kind: c.event_kind, cpu: c.cpu_in, user: c.user_ident,
					group: c.group_ident, requested: c.requested_bits,
					outcome: c.outcome_code};
				r.kind = KIND_EMIT_OK;
				r.seq_out = seq_now;
			end
			due_results.push_back(r);
		end else begin
			if (c.max_records != '0 && c.after_seq < seq_now) begin
				// window starts at the oldest held sequence or just past after_seq, whichever is later
				lo = (seq_now >= DEPTH64) ? seq_now - DEPTH64 + 64'd1 : 64'd1;
				if (c.after_seq + 64'd1 > lo)
					lo = c.after_seq + 64'd1;
				s = lo;
				while (taken < c.max_records) begin
					slot = int'(s % DEPTH64);
					if (ring[slot].seq == s) begin
						r = '0;
						r.kind = KIND_RECORD;
						r.seq_out = ring[slot].seq;
						r.stamp_out = ring[slot].stamp;
						r.object_out = ring[slot].object;
						r.event_out = ring[slot].event_kind;
						r.cpu_out = ring[slot].cpu;
						r.user_out = ring[slot].user;
						r.group_out = ring[slot].group;
						r.requested_out = ring[slot].requested;
						r.outcome_out = ring[slot].outcome;
						due_results.push_back(r);
						taken++;
					end
					if (s == seq_now)
						break;
					s++;
				end
			end
			r = '0;
			r.kind = KIND_END;
			r.seq_out = seq_now;
			r.record_count = taken;
			r.last = 1'b1;
			due_results.push_back(r);
		end
	endtask

	function automatic int field_diff(string field, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %h, actual %h", $time, field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_item_t want;
		int        bad;
		if (!arst_n) begin
			seq_now = '0;
			for (int i = 0; i < RING_DEPTH; i++)
				ring[i] = '0;
			due_results.delete();
			mismatches = 0;
		end else begin
			if (cmd_valid && cmd_ready)
				predict_trace_results(cmd_data);
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing expected, kind %0d seq %h",
						$time, rsp_data.kind, rsp_data.seq_out);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					bad = 0;
					bad += field_diff("kind", want.kind, rsp_data.kind);
					bad += field_diff("seq_out", want.seq_out, rsp_data.seq_out);
					bad += field_diff("stamp_out", want.stamp_out, rsp_data.stamp_out);
					bad += field_diff("object_out", want.object_out, rsp_data.object_out);
					bad += field_diff("event_out", want.event_out, rsp_data.event_out);
					bad += field_diff("cpu_out", want.cpu_out, rsp_data.cpu_out);
					bad += field_diff("user_out", want.user_out, rsp_data.user_out);
					bad += field_diff("group_out", want.group_out, rsp_data.group_out);
					bad += field_diff("requested_out", want.requested_out,
						rsp_data.requested_out);
					bad += field_diff("outcome_out", want.outcome_out, rsp_data.outcome_out);
					bad += field_diff("record_count", want.record_count,
						rsp_data.record_count);
					bad += field_diff("last", want.last, rsp_data.last);
					mismatches += bad;
				end
			end
		end
		waiting = due_results.size();
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// top of the event trace ring testbench: clock, reset, command stimulus, result
// back-pressure and verdict; depends on etrb_pkg, etrb_stream_if, event_trace_ring_buffer_unit and trace_ring_checker

module tb_top;
	import etrb_pkg::*;

	localparam int RANDOM_ITEMS = 460;
	localparam int CYCLE_LIMIT  = 3_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	int          cycles = 0;
	int          fails;
	int          waiting;
	int          sent = 0;
	logic [63:0] emitted = '0;
	int          src_calm = 0;
	int          snk_calm = 0;
	bit          squeezed = 1'b0;

	etrb_stream_if #(.payload_t(cmd_item_t)) cmd ();
	etrb_stream_if #(.payload_t(rsp_item_t)) rsp ();

	event_trace_ring_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	trace_ring_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_ready  (cmd.ready),
		.cmd_data   (cmd.data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_data   (rsp.data),
		.mismatches (fails),
		.waiting    (waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("event_trace_ring_buffer_unit test failed");
			$finish;
		end
	end

	// mostly no gap, some short ones, a few long ones, now and then a calm stretch
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic cmd_item_t noise_cmd();
		cmd_item_t c;
		c.opcode = 1'($urandom_range(0, 1));
		c.event_kind = $urandom;
		c.object_ident = rand64();
		c.user_ident = $urandom;
		c.group_ident = $urandom;
		c.requested_bits = $urandom;
		c.outcome_code = $urandom;
		c.stamp_in = rand64();
		c.cpu_in = 8'($urandom);
		c.after_seq = rand64();
		c.max_records = 8'($urandom);
		return c;
	endfunction

	function automatic cmd_item_t snap_cmd(logic [63:0] after, logic [7:0] limit);
		cmd_item_t c;
		c = noise_cmd();
		c.opcode = OP_SNAPSHOT;
		c.after_seq = after;
		c.max_records = limit;
		return c;
	endfunction

	task automatic send_cmd(input cmd_item_t item);
		int gap;
		gap = idle_len(src_calm);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data <= item;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		sent++;
		if (item.opcode == OP_EMIT && item.event_kind != '0)
			emitted++;
	endtask

	initial begin : result_sink
		int gap;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one long hold-off mid-run so the ring backs up into the command side
			if (!squeezed && sent >= 200) begin
				squeezed = 1'b1;
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			gap = idle_len(snk_calm);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		cmd_item_t   it;
		int          r;
		logic [63:0] back;
		cmd.valid <= 1'b0;
		cmd.data <= '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// snapshots of an empty ring
		send_cmd(snap_cmd('0, 8'd8));
		send_cmd(snap_cmd('1, 8'hFF));
		// rejected emit with everything else at the top of its range
		it = '1;
		it.opcode = OP_EMIT;
		it.event_kind = '0;
		send_cmd(it);
		it.event_kind = '1;
		send_cmd(it);
		it = '0;
		it.event_kind = 32'd1;
		send_cmd(it);
		it = noise_cmd();
		it.opcode = OP_EMIT;
		it.event_kind = 32'h8000_0000;
		it.outcome_code = 32'sh8000_0000;
		send_cmd(it);
		it = noise_cmd();
		it.opcode = OP_EMIT;
		it.event_kind = it.event_kind | 32'd1;
		it.outcome_code = 32'sh7FFF_FFFF;
		send_cmd(it);
		send_cmd(snap_cmd('0, 8'd0));
		send_cmd(snap_cmd('0, 8'hFF));
		send_cmd(snap_cmd(emitted - 64'd1, 8'hFF));
		send_cmd(snap_cmd(emitted, 8'd1));
		send_cmd(snap_cmd('1, 8'd4));
		send_cmd(snap_cmd('0, 8'd1));
		send_cmd(snap_cmd(rand64(), 8'hFF));

		repeat (RANDOM_ITEMS) begin
			it = noise_cmd();
			r = $urandom_range(0, 99);
			if (r < 72) begin
				it.opcode = OP_EMIT;
				if (r < 6)
					it.event_kind = '0;
				else if (it.event_kind == '0)
					it.event_kind = 32'd1;
			end else begin
				it.opcode = OP_SNAPSHOT;
				back = 64'($urandom_range(1, 40));
				r = $urandom_range(0, 99);
				if (r < 10)
					it.after_seq = '0;
				else if (r < 18)
					it.after_seq = rand64();
				else if (r < 23)
					it.after_seq = '1;
				else if (r < 30)
					it.after_seq = emitted;
				else
					it.after_seq = (emitted > back) ? emitted - back : '0;
				r = $urandom_range(0, 99);
				if (r < 8)
					it.max_records = '0;
				else if (r < 16)
					it.max_records = '1;
				else if (r >= 26)
					it.max_records = 8'($urandom_range(1, 40));
			end
			send_cmd(it);
		end
		cmd.valid <= 1'b0;

		do @(negedge clk); while (waiting != 0);
		repeat (80) @(negedge clk);
		if (waiting != 0)
			$display("%0d results never arrived", waiting);
		if (fails == 0 && waiting == 0) begin
			$display("event_trace_ring_buffer_unit test passed");
		end else begin
			$display("event_trace_ring_buffer_unit test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/etrb_pkg.sv
src/etrb_stream_if.sv
src/event_trace_ring_buffer_unit.sv
src/etrb_checker.sv
test/trace_ring_checker.sv
test/tb_top.sv
